// File: src/complex_arithmetic_unit_top_defines.svh
// Assertion macros for the complex arithmetic unit checker.
// No dependencies; included by the checker file.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// Plain clocked property.
`define CAU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// Clocked property, ignored while reset is high.
`define CAU_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// File: src/cau_pkg.sv
// Shared codes, pipeline sizes and stage types for the complex arithmetic unit.
// No dependencies.
`default_nettype none

package cau_pkg;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_OVF  = 2'd1;
   localparam logic [1:0] STAT_DIVZ = 2'd2;

   localparam int DIV_STEPS = 32;
   // clock edges from the accepting edge to the edge that takes the result
   localparam int LATENCY   = DIV_STEPS + 6;

   typedef struct packed {
      logic               neg;
      logic               big;
      logic [63:0]        rem;
      logic [31:0]        quo;
      logic [15:0]        low;
      logic signed [48:0] fin;
   } lane_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  mode;
      logic        dz;
      logic [63:0] dvs;
      lane_type    re;
      lane_type    im;
   } stage_type;

endpackage

`default_nettype wire

// File: src/complex_arithmetic_unit_top.sv
// Complex add/sub/mul/div on signed Q16.16 operands, fully pipelined.
// Depends on cau_pkg.
//
// channel   ports                                   handshake
// request   req_mode, req_a_*, req_b_*              start & !busy
// response  rsp_result_real/imag, rsp_status        rsp_valid, one-cycle strobe
//
// One item per cycle.
// Depth is set by the 32-step restoring divider, one quotient bit per stage,
// plus input, multiply, sum, magnitude, divider setup and output stages.
// busy is always low. Synchronous reset clears the valid bits only.
`default_nettype none

module complex_arithmetic_unit_top
   import cau_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_mode,
   input  wire logic signed [31:0] req_a_real,
   input  wire logic signed [31:0] req_a_imag,
   input  wire logic signed [31:0] req_b_real,
   input  wire logic signed [31:0] req_b_imag,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_result_real,
   output logic signed [31:0]      rsp_result_imag,
   output logic [1:0]              rsp_status
);

   localparam logic signed [48:0] MAX32 = 49'sd2147483647;
   localparam logic signed [48:0] MIN32 = -49'sd2147483648;

   // stage A: operands
   logic               a_valid_ff;
   logic [1:0]         a_mode_ff;
   logic signed [31:0] a_ar_ff, a_ai_ff, a_br_ff, a_bi_ff;

   // stage B: products
   logic               b_valid_ff;
   logic [1:0]         b_mode_ff;
   logic               b_dz_ff;
   logic signed [63:0] b_rr_ff, b_ii_ff, b_ri_ff, b_ir_ff, b_dr_ff, b_di_ff;
   logic signed [32:0] b_as_re_ff, b_as_im_ff;

   // stage C: sums
   logic               c_valid_ff;
   logic [1:0]         c_mode_ff;
   logic               c_dz_ff;
   logic [63:0]        c_dvs_ff;
   logic signed [64:0] c_re_ff, c_im_ff;

   // stage D: magnitudes
   logic               d_valid_ff;
   logic [1:0]         d_mode_ff;
   logic               d_dz_ff;
   logic [63:0]        d_dvs_ff;
   logic               d_re_neg_ff, d_im_neg_ff;
   logic [63:0]        d_re_mag_ff, d_im_mag_ff;
   logic signed [48:0] d_re_fin_ff, d_im_fin_ff;

   stage_type div_ff [0:DIV_STEPS];
   stage_type div_in [0:DIV_STEPS];

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_re_ff, rsp_im_ff;
   logic [1:0]         rsp_status_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      a_mode_ff <= req_mode;
      a_ar_ff   <= req_a_real;
      a_ai_ff   <= req_a_imag;
      a_br_ff   <= req_b_real;
      a_bi_ff   <= req_b_imag;
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      b_mode_ff <= a_mode_ff;
      b_dz_ff   <= (a_br_ff == 32'sd0) && (a_bi_ff == 32'sd0);
      b_rr_ff   <= a_ar_ff * a_br_ff;
      b_ii_ff   <= a_ai_ff * a_bi_ff;
      b_ri_ff   <= a_ar_ff * a_bi_ff;
      b_ir_ff   <= a_ai_ff * a_br_ff;
      b_dr_ff   <= a_br_ff * a_br_ff;
      b_di_ff   <= a_bi_ff * a_bi_ff;
      if (a_mode_ff == MODE_SUB) begin
         b_as_re_ff <= 33'(a_ar_ff) - 33'(a_br_ff);
         b_as_im_ff <= 33'(a_ai_ff) - 33'(a_bi_ff);
      end else begin
         b_as_re_ff <= 33'(a_ar_ff) + 33'(a_br_ff);
         b_as_im_ff <= 33'(a_ai_ff) + 33'(a_bi_ff);
      end
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_mode_ff <= b_mode_ff;
      c_dz_ff   <= b_dz_ff;
      c_dvs_ff  <= $unsigned(b_dr_ff) + $unsigned(b_di_ff);
      unique case (b_mode_ff)
         MODE_MUL: begin
            c_re_ff <= 65'(b_rr_ff) - 65'(b_ii_ff);
            c_im_ff <= 65'(b_ri_ff) + 65'(b_ir_ff);
         end
         MODE_DIV: begin
            c_re_ff <= 65'(b_rr_ff) + 65'(b_ii_ff);
            c_im_ff <= 65'(b_ir_ff) - 65'(b_ri_ff);
         end
         default: begin
            c_re_ff <= 65'(b_as_re_ff);
            c_im_ff <= 65'(b_as_im_ff);
         end
      endcase
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_mode_ff   <= c_mode_ff;
      d_dz_ff     <= c_dz_ff;
      d_dvs_ff    <= c_dvs_ff;
      d_re_neg_ff <= c_re_ff[64];
      d_im_neg_ff <= c_im_ff[64];
      d_re_mag_ff <= c_re_ff[64] ? 64'(-c_re_ff) : c_re_ff[63:0];
      d_im_mag_ff <= c_im_ff[64] ? 64'(-c_im_ff) : c_im_ff[63:0];
      // multiply: arithmetic shift gives the floor
      if (c_mode_ff == MODE_MUL) begin
         d_re_fin_ff <= 49'(c_re_ff >>> 16);
         d_im_fin_ff <= 49'(c_im_ff >>> 16);
      end else begin
         d_re_fin_ff <= 49'(c_re_ff);
         d_im_fin_ff <= 49'(c_im_ff);
      end
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
   end

   // divider setup: quotient of mag*2^16/d fits 32 bits unless mag >= d*2^16
   always_comb begin
      div_in[0]          = '0;
      div_in[0].valid    = d_valid_ff & ~reset;
      div_in[0].mode     = d_mode_ff;
      div_in[0].dz       = d_dz_ff;
      div_in[0].dvs      = d_dvs_ff;
      div_in[0].re.neg   = d_re_neg_ff;
      div_in[0].re.big   = {16'd0, d_re_mag_ff} >= {d_dvs_ff, 16'd0};
      div_in[0].re.rem   = {16'd0, d_re_mag_ff[63:16]};
      div_in[0].re.low   = d_re_mag_ff[15:0];
      div_in[0].re.fin   = d_re_fin_ff;
      div_in[0].im.neg   = d_im_neg_ff;
      div_in[0].im.big   = {16'd0, d_im_mag_ff} >= {d_dvs_ff, 16'd0};
      div_in[0].im.rem   = {16'd0, d_im_mag_ff[63:16]};
      div_in[0].im.low   = d_im_mag_ff[15:0];
      div_in[0].im.fin   = d_im_fin_ff;
   end

   // valid bits are cleared on the way in, so each stage has a single update
   for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         div_ff[k] <= div_in[k];
      end
   end

   // one restoring step per stage, quotient bit DIV_STEPS-1-k
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div_step
      localparam int BIT = DIV_STEPS - 1 - k;
      logic        re_x, im_x;
      logic [64:0] re_t, im_t, dv;
      logic        re_ge, im_ge;

      if (BIT >= 16) begin : g_low
         assign re_x = div_ff[k].re.low[BIT-16];
         assign im_x = div_ff[k].im.low[BIT-16];
      end else begin : g_zero
         assign re_x = 1'b0;
         assign im_x = 1'b0;
      end

      assign dv    = {1'b0, div_ff[k].dvs};
      assign re_t  = {div_ff[k].re.rem, re_x};
      assign im_t  = {div_ff[k].im.rem, im_x};
      assign re_ge = re_t >= dv;
      assign im_ge = im_t >= dv;

      always_comb begin
         div_in[k+1]        = div_ff[k];
         div_in[k+1].valid  = div_ff[k].valid & ~reset;
         div_in[k+1].re.rem = re_ge ? 64'(re_t - dv) : re_t[63:0];
         div_in[k+1].im.rem = im_ge ? 64'(im_t - dv) : im_t[63:0];
         div_in[k+1].re.quo = {div_ff[k].re.quo[30:0], re_ge};
         div_in[k+1].im.quo = {div_ff[k].im.quo[30:0], im_ge};
      end
   end

   // returns {saturated, value}
   function automatic logic [32:0] lane_out(lane_type ln, logic is_div);
      logic [32:0]        mag;
      logic signed [48:0] f;
      mag = {ln.big, ln.quo};
      f   = $signed(ln.fin);
      if (is_div) begin
         if (!ln.neg) begin
            if (mag > 33'h07FFFFFFF) return {1'b1, 32'h7FFFFFFF};
            return {1'b0, ln.quo};
         end
         if (mag > 33'h080000000) return {1'b1, 32'h80000000};
         return {1'b0, 32'(-ln.quo)};
      end
      if (f > MAX32) return {1'b1, 32'h7FFFFFFF};
      if (f < MIN32) return {1'b1, 32'h80000000};
      return {1'b0, f[31:0]};
   endfunction

   logic [32:0] out_re, out_im;
   logic        out_div;

   assign out_div = div_ff[DIV_STEPS].mode == MODE_DIV;
   assign out_re  = lane_out(div_ff[DIV_STEPS].re, out_div);
   assign out_im  = lane_out(div_ff[DIV_STEPS].im, out_div);

   always_ff @(posedge clock) begin
      if (out_div && div_ff[DIV_STEPS].dz) begin
         rsp_re_ff     <= '0;
         rsp_im_ff     <= '0;
         rsp_status_ff <= STAT_DIVZ;
      end else begin
         rsp_re_ff     <= out_re[31:0];
         rsp_im_ff     <= out_im[31:0];
         rsp_status_ff <= (out_re[32] | out_im[32]) ? STAT_OVF : STAT_OK;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_ff[DIV_STEPS].valid;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_real = rsp_re_ff;
   assign rsp_result_imag = rsp_im_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

// File: src/cau_checker.sv
// Port-level checks for complex_arithmetic_unit_top and its bind.
// Depends on cau_pkg and complex_arithmetic_unit_top_defines.svh.
`default_nettype none
`include "complex_arithmetic_unit_top_defines.svh"

module cau_checker
   import cau_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [1:0]  req_mode,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_result_real,
   input wire logic [31:0] rsp_result_imag,
   input wire logic [1:0]  rsp_status
);

   `CAU_ASSERT(a_reset_quiet, $past(reset) |-> !rsp_valid, "result strobe right after reset")
   `CAU_ASSERT_RST(a_latency, rsp_valid |-> $past(start && !busy, LATENCY), "result without item")
   `CAU_ASSERT_RST(a_divz_zero, rsp_valid && rsp_status == STAT_DIVZ |-> rsp_result_real == 32'd0 && rsp_result_imag == 32'd0 && $past(req_mode, LATENCY) == MODE_DIV, "bad divide-by-zero result")
   `CAU_ASSERT_RST(a_ovf_sat, rsp_valid && rsp_status == STAT_OVF |-> rsp_result_real == 32'h7FFFFFFF || rsp_result_real == 32'h80000000 || rsp_result_imag == 32'h7FFFFFFF || rsp_result_imag == 32'h80000000, "overflow without saturated part")

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_mode        (req_mode),
   .rsp_valid       (rsp_valid),
   .rsp_result_real (rsp_result_real),
   .rsp_result_imag (rsp_result_imag),
   .rsp_status      (rsp_status)
);

`default_nettype wire

// File: sim/testbench.sv
// Testbench for complex_arithmetic_unit_top: directed and random complex items,
// checked against an in-bench predictor of the Q16.16 add/sub/mul/div behavior.
// Depends on cau_pkg and the RTL top level.
`default_nettype none

module testbench
   import cau_pkg::*;
();

   typedef struct {
      logic [1:0]         mode;
      logic signed [31:0] ar;
      logic signed [31:0] ai;
      logic signed [31:0] br;
      logic signed [31:0] bi;
   } operands_type;

   typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic [1:0]         status;
   } cresult_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [1:0] req_mode = '0;
   logic signed [31:0] req_a_real = '0, req_a_imag = '0, req_b_real = '0, req_b_imag = '0;
   wire busy, rsp_valid;
   wire signed [31:0] rsp_result_real, rsp_result_imag;
   wire [1:0] rsp_status;

   operands_type pending_q[$];
   cresult_type  expected_q[$];
   int        mismatches = 0;
   int        checked = 0;
   int        sent = 0;
   bit        stim_done = 1'b0;
   bit        quiet_stretch = 1'b0;
   int        mode_count[4];
   int        stat_count[3];

   complex_arithmetic_unit_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_a_real(req_a_real), .req_a_imag(req_a_imag),
      .req_b_real(req_b_real), .req_b_imag(req_b_imag),
      .rsp_valid(rsp_valid), .rsp_result_real(rsp_result_real),
      .rsp_result_imag(rsp_result_imag), .rsp_status(rsp_status)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                  inout bit ovf);
      if (v > 128'sd2147483647) begin
         ovf = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (v < -128'sd2147483648) begin
         ovf = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // (n * 2^16) / d truncated toward zero; large quotients are saturated later by clamp32
   function automatic logic signed [127:0] scaled_quotient(input logic signed [127:0] n,
                                                           input logic signed [127:0] d);
      logic signed [127:0] mag;
      mag = (n < 0) ? -n : n;
      mag = (mag <<< 16) / d;
      return (n < 0) ? -mag : mag;
   endfunction

   function automatic cresult_type complex_result(input operands_type op);
      cresult_type r;
      bit ovf;
      logic signed [127:0] ar, ai, br, bi, x, y, d;
      ovf = 1'b0;
      ar = op.ar; ai = op.ai; br = op.br; bi = op.bi;
      case (op.mode)
         MODE_ADD: begin x = ar + br; y = ai + bi; end
         MODE_SUB: begin x = ar - br; y = ai - bi; end
         MODE_MUL: begin
            x = (ar * br - ai * bi) >>> 16;
            y = (ar * bi + ai * br) >>> 16;
         end
         default: begin
            d = br * br + bi * bi;
            if (d == 0) begin
               r.re = '0; r.im = '0; r.status = STAT_DIVZ;
               return r;
            end
            x = scaled_quotient(ar * br + ai * bi, d);
            y = scaled_quotient(ai * br - ar * bi, d);
         end
      endcase
      r.re = clamp32(x, ovf);
      r.im = clamp32(y, ovf);
      r.status = ovf ? STAT_OVF : STAT_OK;
      return r;
   endfunction

   function automatic logic signed [31:0] pick_part();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
         2: return $signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000;
         3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         4: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFFFFFF;
               1: return 32'sh80000000;
               2: return 32'sh0;
               default: return -32'sh1;
            endcase
         end
         default: return $signed($urandom_range(0, 32'hFFFFF)) - 32'sh80000;
      endcase
   endfunction

   function automatic operands_type make_op(input logic [1:0] m, input logic signed [31:0] a,
                                         input logic signed [31:0] b, input logic signed [31:0] c,
                                         input logic signed [31:0] e);
      operands_type o;
      o.mode = m; o.ar = a; o.ai = b; o.br = c; o.bi = e;
      return o;
   endfunction

   initial begin
      operands_type op;
      // directed: extremes, every mode, overflow, divide by zero, floor on negatives
      pending_q.push_back(make_op(MODE_ADD, 32'sh7FFFFFFF, 32'sh80000000, 32'sh1, -32'sh1));
      pending_q.push_back(make_op(MODE_ADD, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0));
      pending_q.push_back(make_op(MODE_SUB, 32'sh80000000, 32'sh7FFFFFFF, 32'sh1, -32'sh1));
      pending_q.push_back(make_op(MODE_SUB, 32'sh10000, 32'sh20000, 32'sh30000, -32'sh40000));
      pending_q.push_back(make_op(MODE_MUL, 32'sh10000, 32'sh0, 32'sh10000, 32'sh0));
      pending_q.push_back(make_op(MODE_MUL, 32'sh0, 32'sh10000, 32'sh0, 32'sh10000));
      pending_q.push_back(make_op(MODE_MUL, -32'sh1, 32'sh0, 32'sh1, 32'sh0));
      pending_q.push_back(make_op(MODE_MUL, 32'sh80000000, 32'sh80000000,
                                  32'sh80000000, 32'sh80000000));
      pending_q.push_back(make_op(MODE_MUL, 32'sh7FFFFFFF, 32'sh80000000,
                                  32'sh7FFFFFFF, 32'sh7FFFFFFF));
      pending_q.push_back(make_op(MODE_DIV, 32'sh10000, 32'sh10000, 0, 0));
      pending_q.push_back(make_op(MODE_DIV, 0, 0, 0, 0));
      pending_q.push_back(make_op(MODE_DIV, 32'sh10000, 0, 32'sh10000, 0));
      pending_q.push_back(make_op(MODE_DIV, -32'sh30000, 32'sh20000, 32'sh20000, 32'sh10000));
      pending_q.push_back(make_op(MODE_DIV, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh1, 0));
      pending_q.push_back(make_op(MODE_DIV, 32'sh80000000, 32'sh80000000, 0, 32'sh1));
      pending_q.push_back(make_op(MODE_DIV, 32'sh1, 32'sh0, 32'sh7FFFFFFF, 32'sh80000000));
      pending_q.push_back(make_op(MODE_DIV, 32'sh80000000, 32'sh7FFFFFFF,
                                  32'sh80000000, 32'sh80000000));
      pending_q.push_back(make_op(MODE_DIV, -32'sh1, 32'sh0, 32'sh0, -32'sh1));
      pending_q.push_back(make_op(MODE_DIV, 32'sh1, -32'sh1, 32'sh10000, 32'sh10000));
      repeat (1900) begin
         op.mode = 2'($urandom_range(0, 3));
         op.ar = pick_part(); op.ai = pick_part();
         op.br = pick_part(); op.bi = pick_part();
         if (op.mode == MODE_DIV && $urandom_range(0, 19) == 0) begin
            op.br = 0; op.bi = 0;
         end
         pending_q.push_back(op);
      end
   end

   // driver: present the next item at the falling edge; hold it until taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            if (pending_q.size() > 0) void'(pending_q.pop_front());
            sent++;
         end
         quiet_stretch = (sent >= 600 && sent < 900);
         if (pending_q.size() > 0 && (quiet_stretch || $urandom_range(0, 99) >= 11)) begin
            start      <= 1'b1;
            req_mode   <= pending_q[0].mode;
            req_a_real <= pending_q[0].ar;
            req_a_imag <= pending_q[0].ai;
            req_b_real <= pending_q[0].br;
            req_b_imag <= pending_q[0].bi;
         end else begin
            start <= 1'b0;
            if (pending_q.size() == 0) stim_done = 1'b1;
         end
      end
   end

   // monitor: record accepted items and check results
   always @(posedge clock) begin
      cresult_type exp_r;
      operands_type taken;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result at %0t", $time);
            end else begin
               exp_r = expected_q.pop_front();
               checked++;
               if (rsp_result_real !== exp_r.re || rsp_result_imag !== exp_r.im ||
                   rsp_status !== exp_r.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch #%0d: exp re=%h im=%h st=%0d got re=%h im=%h st=%0d",
                              checked, exp_r.re, exp_r.im, exp_r.status,
                              rsp_result_real, rsp_result_imag, rsp_status);
               end
            end
         end
         if (start && !busy) begin
            taken.mode = req_mode; taken.ar = req_a_real; taken.ai = req_a_imag;
            taken.br = req_b_real; taken.bi = req_b_imag;
            exp_r = complex_result(taken);
            expected_q.push_back(exp_r);
            mode_count[taken.mode]++;
            stat_count[exp_r.status]++;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      @(posedge clock);
      wait (expected_q.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d results: add %0d, sub %0d, mul %0d, div %0d", checked,
               mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
      $display("status mix: ok %0d, saturated %0d, divide by zero %0d",
               stat_count[0], stat_count[1], stat_count[2]);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
+incdir+src
src/cau_pkg.sv
src/complex_arithmetic_unit_top.sv
src/cau_checker.sv
sim/testbench.sv
